>>> rtl/dmp_pkg.sv
// shared constants, register codes, control struct and max function for the 2x2 max pooling block
package dmp_pkg;

    localparam int PIXEL_W      = 16;
    localparam int LOW_WIDTH_W  = 10;
    localparam int LOW_HEIGHT_W = 11;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 11;

    localparam int DEF_MAX_LOW_WIDTH  = 512;
    localparam int DEF_MAX_LOW_HEIGHT = 1024;

    localparam logic [LOW_WIDTH_W-1:0]  RESET_LOW_WIDTH  = 10'd320;
    localparam logic [LOW_HEIGHT_W-1:0] RESET_LOW_HEIGHT = 11'd240;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_HEIGHT = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic emit;
        logic combine;
        logic row_end;
        logic frame_end;
    } dmp_ctrl_t;

    function automatic logic [PIXEL_W-1:0] pix_max(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/dmp_ram.sv
// generic single-clock ram with one write port and one registered read port
module dmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dmp_ctrl.sv
// configuration registers, frame counters and per-pixel line store control
module dmp_ctrl
    import dmp_pkg::*;
#(
    parameter int MAX_LOW_WIDTH  = DEF_MAX_LOW_WIDTH,
    parameter int MAX_LOW_HEIGHT = DEF_MAX_LOW_HEIGHT,
    localparam int AW = (MAX_LOW_WIDTH > 1) ? $clog2(MAX_LOW_WIDTH) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    output dmp_ctrl_t              ctrl,
    output logic [AW-1:0]          addr
);

    localparam int CW = $clog2(2 * MAX_LOW_WIDTH + 1);
    localparam int RW = $clog2(2 * MAX_LOW_HEIGHT + 1);
    localparam int XW = (CW > LOW_WIDTH_W) ? CW : LOW_WIDTH_W;
    localparam int XH = (RW > LOW_HEIGHT_W) ? RW : LOW_HEIGHT_W;
    localparam int RX = RW + 3;

    logic [LOW_WIDTH_W-1:0]  low_width_reg;
    logic [LOW_HEIGHT_W-1:0] low_height_reg;
    logic [CW-1:0]           col_reg, col_next;
    logic [RW-1:0]           row_reg, row_next;

    logic [XW-1:0] lw_x, weff_x;
    logic [XH-1:0] lh_x, heff_x;
    logic [CW-1:0] weff_c, hw, hw_m1, c_eff;
    logic [RW-1:0] heff_r, hh, hh_m1, r_eff;
    logic          wrap, odd, row0, last_r, last_c, odd_row_ok, even_row_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_width_reg  <= RESET_LOW_WIDTH;
            low_height_reg <= RESET_LOW_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOW_WIDTH:  low_width_reg  <= cfg_data[LOW_WIDTH_W-1:0];
                REG_LOW_HEIGHT: low_height_reg <= cfg_data[LOW_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the configured size to the supported range
    always_comb
    begin
        lw_x = XW'(low_width_reg);
        if (lw_x == '0)
            weff_x = XW'(1);
        else if (lw_x > XW'(MAX_LOW_WIDTH))
            weff_x = XW'(MAX_LOW_WIDTH);
        else
            weff_x = lw_x;

        lh_x = XH'(low_height_reg);
        if (lh_x < XH'(2))
            heff_x = XH'(2);
        else if (lh_x > XH'(MAX_LOW_HEIGHT))
            heff_x = XH'(MAX_LOW_HEIGHT);
        else
            heff_x = lh_x;
    end

    assign weff_c = weff_x[CW-1:0];
    assign heff_r = heff_x[RW-1:0];
    assign hw     = {weff_c[CW-2:0], 1'b0};
    assign hh     = {heff_r[RW-2:0], 1'b0};
    assign hw_m1  = hw - CW'(1);
    assign hh_m1  = hh - RW'(1);

    // counters left outside the frame by a size change restart it
    assign wrap  = (col_reg >= hw) || (row_reg >= hh);
    assign c_eff = wrap ? '0 : col_reg;
    assign r_eff = wrap ? '0 : row_reg;

    assign odd    = c_eff[0];
    assign row0   = (r_eff == '0);
    assign last_r = (r_eff == hh_m1);
    assign last_c = (c_eff == hw_m1);
    assign addr   = c_eff[AW:1];

    assign odd_row_ok  = r_eff[0] && ((RX'(r_eff) + RX'(5)) <= RX'(hh));
    assign even_row_ok = !r_eff[0] && ((RX'(r_eff) + RX'(4)) <= RX'(hh));

    always_comb
    begin
        ctrl           = '0;
        ctrl.rd_en     = accept && !odd;
        ctrl.row_end   = last_c;
        ctrl.frame_end = last_c && last_r;
        if (odd)
        begin
            priority if (row0 || last_r)
            begin
                ctrl.emit = 1'b1;
            end
            else if (odd_row_ok)
            begin
                ctrl.wr_en = accept;
            end
            else if (even_row_ok)
            begin
                ctrl.emit    = 1'b1;
                ctrl.combine = 1'b1;
            end
            else
            begin
                // the two rows before the last give nothing
                ctrl.emit = 1'b0;
            end
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_c)
            begin
                col_next = '0;
                row_next = last_r ? '0 : r_eff + RW'(1);
            end
            else
            begin
                col_next = c_eff + CW'(1);
                row_next = r_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/disparity_max_pool_2x2.sv
// top level of the offset 2x2 max pooling downsampler for disparity frames
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  in       | in_valid / in_stall   | high_pixel
//  out      | out_valid / out_stall | low_pixel, row_end, frame_end
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one input item per cycle while in_stall is low; a result is registered in the output register
// when the second pixel of its pair is accepted, fed by the line store read-modify path
// the line store read is issued on the first pixel of a pair, the write on the second
// reset clears counters and loads the default size; the line store needs no clearing
// in_stall is raised only while a result waits in the output register under out_stall
module disparity_max_pool_2x2
    import dmp_pkg::*;
#(
    parameter int MAX_LOW_WIDTH  = DEF_MAX_LOW_WIDTH,
    parameter int MAX_LOW_HEIGHT = DEF_MAX_LOW_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIXEL_W-1:0]     high_pixel,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIXEL_W-1:0]     low_pixel,
    output logic                   row_end,
    output logic                   frame_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_LOW_WIDTH > 1) ? $clog2(MAX_LOW_WIDTH) : 1;

    dmp_ctrl_t        ctrl;
    logic [AW-1:0]    addr;
    logic             accept;
    logic [PIXEL_W-1:0] pair_hold_reg, pair_max, rd_data, result;
    logic             out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] low_pixel_reg;
    logic             row_end_reg, frame_end_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    dmp_ctrl #(
        .MAX_LOW_WIDTH  (MAX_LOW_WIDTH),
        .MAX_LOW_HEIGHT (MAX_LOW_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .ctrl      (ctrl),
        .addr      (addr)
    );

    assign pair_max = pix_max(pair_hold_reg, high_pixel);

    // pair maxima of the odd row
    dmp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_LOW_WIDTH)
    ) u_odd_row_store (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (addr),
        .wr_data (pair_max),
        .rd_en   (ctrl.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    assign result = ctrl.combine ? pix_max(rd_data, pair_max) : pair_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_hold_reg <= '0;
        end
        else if (ctrl.rd_en)
        begin
            pair_hold_reg <= high_pixel;
        end
    end

    assign out_valid_next = (accept && ctrl.emit) || in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ctrl.emit)
        begin
            low_pixel_reg <= result;
            row_end_reg   <= ctrl.row_end;
            frame_end_reg <= ctrl.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign low_pixel = low_pixel_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> test/disparity_max_pool_2x2_tb.sv
// self-checking testbench for the offset 2x2 max pooling downsampler, predicted pixel by pixel
module disparity_max_pool_2x2_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmp_pkg::*;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        logic               frame_end;
    } pooled_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     high_pixel = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PIXEL_W-1:0]     low_pixel;
    logic                   row_end;
    logic                   frame_end;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_LOW_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [LOW_WIDTH_W-1:0]  cur_width = RESET_LOW_WIDTH;
    logic [LOW_HEIGHT_W-1:0] cur_height = RESET_LOW_HEIGHT;
    int unsigned             col_idx = 0;
    int unsigned             row_idx = 0;
    logic [PIXEL_W-1:0]      pair_first = '0;
    logic [PIXEL_W-1:0]      odd_row_max [DEF_MAX_LOW_WIDTH];

    pooled_t pooled_queue [$];
    int      mismatches = 0;
    int      random_pixels = 0;
    bit      calm = 1'b0;

    disparity_max_pool_2x2 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .high_pixel (high_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .low_pixel  (low_pixel),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        if (cur_width < 1)
            return 1;
        if (cur_width > DEF_MAX_LOW_WIDTH)
            return DEF_MAX_LOW_WIDTH;
        return cur_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cur_height < 2)
            return 2;
        if (cur_height > DEF_MAX_LOW_HEIGHT)
            return DEF_MAX_LOW_HEIGHT;
        return cur_height;
    endfunction

    function automatic int frame_size();
        return 4 * eff_width() * eff_height();
    endfunction

    function automatic void pool_step(input logic [PIXEL_W-1:0] p);
        int unsigned        w;
        int unsigned        hw;
        int unsigned        hh;
        int unsigned        k;
        logic [PIXEL_W-1:0] m;
        pooled_t            res;
        bit                 emit;
        w = eff_width();
        hw = 2 * w;
        hh = 2 * eff_height();
        emit = 1'b0;
        res = '0;
        // counters left outside a shrunken frame restart it
        if (col_idx >= hw || row_idx >= hh)
        begin
            col_idx = 0;
            row_idx = 0;
        end
        if (col_idx[0] == 1'b0)
            pair_first = p;
        else
        begin
            m = (pair_first > p) ? pair_first : p;
            k = col_idx >> 1;
            if (row_idx == 0 || row_idx == hh - 1)
            begin
                res.pixel = m;
                emit = 1'b1;
            end
            else if (row_idx[0] && row_idx + 4 <= hh - 1)
                odd_row_max[k] = m;
            else if (!row_idx[0] && row_idx + 4 <= hh)
            begin
                res.pixel = (odd_row_max[k] > m) ? odd_row_max[k] : m;
                emit = 1'b1;
            end
            // rows 2h-3 and 2h-2 give nothing
            if (emit)
            begin
                res.row_end = (k == w - 1);
                res.frame_end = (k == w - 1) && (row_idx == hh - 1);
                pooled_queue.push_back(res);
            end
        end
        if (col_idx == hw - 1)
        begin
            col_idx = 0;
            row_idx = (row_idx == hh - 1) ? 0 : row_idx + 1;
        end
        else
            col_idx = col_idx + 1;
    endfunction

    always @(posedge clk)
    begin : monitor
        pooled_t exp_item;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOW_WIDTH)
                    cur_width = cfg_data[LOW_WIDTH_W-1:0];
                else
                    cur_height = cfg_data[LOW_HEIGHT_W-1:0];
            end
            if (in_valid && !in_stall)
                pool_step(high_pixel);
            if (out_valid && !out_stall)
            begin
                if (pooled_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pixel %h row_end %b frame_end %b",
                                 low_pixel, row_end, frame_end);
                end
                else
                begin
                    exp_item = pooled_queue.pop_front();
                    if (exp_item.pixel !== low_pixel || exp_item.row_end !== row_end
                        || exp_item.frame_end !== frame_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result differs: expected %h/%b/%b got %h/%b/%b",
                                     exp_item.pixel, exp_item.row_end, exp_item.frame_end,
                                     low_pixel, row_end, frame_end);
                    end
                end
            end
        end
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 30);

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return PIXEL_W'($urandom_range(0, 15));
            default: return PIXEL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] p);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        high_pixel <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_pixels(input int n);
        repeat (n)
            send_pixel(rand_pixel());
    endtask

    // only while idle: drain results, let the pipeline settle, then write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pooled_queue.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input int w_raw, input int h_raw);
        write_reg(REG_LOW_WIDTH, CFG_DATA_W'(w_raw));
        write_reg(REG_LOW_HEIGHT, CFG_DATA_W'(h_raw));
    endtask

    task automatic test_counter_restart();
        // part of row 0 at the reset size, then a narrower frame
        send_pixels(11);
        set_size(2, 3);
        send_pixels(frame_size());
        // stop in row 6, then a shorter frame
        set_size(2, 4);
        send_pixels(25);
        write_reg(REG_LOW_HEIGHT, CFG_DATA_W'(2));
        send_pixels(frame_size());
    endtask

    task automatic test_tiny_frame();
        set_size(1, 2);
        send_pixel(16'h0000);
        send_pixel(16'hffff);
        send_pixel(16'hffff);
        send_pixel(16'h0000);
        send_pixel(16'h5555);
        send_pixel(16'haaaa);
        send_pixel(16'h8000);
        send_pixel(16'h0001);
    endtask

    task automatic test_combine_rows();
        set_size(2, 3);
        for (int i = 0; i < 24; i++)
            send_pixel(i[0] ? PIXEL_W'(i * 2749) : PIXEL_W'(16'hffff - i * 1931));
    endtask

    task automatic test_size_extremes();
        // width data with only the unused top bit set reads as zero
        set_size(11'h400, 0);
        send_pixels(frame_size());
        set_size(1, 1);
        send_pixels(frame_size());
        // clamped width: one full high row and a bit, then a narrow frame restarts
        set_size(11'h3ff, 3);
        send_pixels(2 * eff_width() + 8);
        set_size(1, 2);
        send_pixels(frame_size());
        // clamped height: the top rows only, then cut below the current row
        set_size(1, 11'h7ff);
        send_pixels(24);
        write_reg(REG_LOW_HEIGHT, CFG_DATA_W'(2));
        send_pixels(frame_size());
    endtask

    task automatic test_random_frames();
        int n;
        int w_raw;
        int h_raw;
        int pick;
        while (random_pixels < 600)
        begin
            calm = (random_pixels >= 200 && random_pixels < 400);
            w_raw = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            h_raw = ($urandom_range(0, 4) != 0) ? $urandom_range(2, 5) : $urandom_range(6, 10);
            w_raw = w_raw | ($urandom_range(0, 1) << 10);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                set_size(w_raw, h_raw);
            else if (pick < 7)
                write_reg(REG_LOW_WIDTH, CFG_DATA_W'(w_raw));
            else if (pick < 8)
                write_reg(REG_LOW_HEIGHT, CFG_DATA_W'(h_raw));
            if ($urandom_range(0, 9) == 0 && eff_height() >= 3)
            begin
                // broken frame: stop in row 4 or later, then cut the height below it
                n = $urandom_range(8 * eff_width(), frame_size() - 1);
                send_pixels(n);
                write_reg(REG_LOW_HEIGHT,
                          CFG_DATA_W'($urandom_range(0, (n / (2 * eff_width())) / 2)));
                // one whole frame at the cut size leaves the counters at the frame start
                send_pixels(frame_size());
                n += frame_size();
            end
            else
            begin
                n = frame_size();
                send_pixels(n);
            end
            random_pixels += n;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_counter_restart();
        test_tiny_frame();
        test_combine_rows();
        test_size_extremes();
        test_random_frames();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pooled_queue.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && pooled_queue.size() == 0)
            $display("disparity_max_pool_2x2: match");
        else
            $display("disparity_max_pool_2x2: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("disparity_max_pool_2x2: mismatch");
        $finish;
    end

endmodule
